/* rtl/rgbls_pkg.sv */
// Shared types and constants of the RGB LED strip frame driver.
// No dependencies; the front end, queue, back end and top level import this package.
`default_nettype none

package rgbls_pkg;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_BRIGHT = 2'd1;
  localparam logic [1:0] ACT_SHOW   = 2'd2;
  localparam logic [1:0] ACT_TICK   = 2'd3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD   = 3'd6;

  localparam logic [8:0] RST_LED_COUNT    = 9'd0;
  localparam logic [1:0] RST_RED_OFFSET   = 2'd1;
  localparam logic [1:0] RST_GREEN_OFFSET = 2'd0;
  localparam logic [1:0] RST_BLUE_OFFSET  = 2'd2;
  localparam logic [7:0] RST_ZERO_HIGH    = 8'd8;
  localparam logic [7:0] RST_ONE_HIGH     = 8'd28;
  localparam logic [7:0] RST_BIT_PERIOD   = 8'd37;

  // offset code that disables storing a color
  localparam logic [1:0] OFF_NONE = 2'b11;
  // dividend used when brightness goes to full
  localparam logic [15:0] FULL_SCALE_NUM = 16'd65535;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [8:0] led_count;
    logic [1:0] red_offset;
    logic [1:0] green_offset;
    logic [1:0] blue_offset;
    logic [7:0] zero_high_ticks;
    logic [7:0] one_high_ticks;
    logic [7:0] bit_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] level;
  } in_item_t;

  typedef struct packed {
    logic pin_level;
    logic sending;
    logic frame_done;
    logic rejected;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_REJECT,
    CMD_BRIGHT,
    CMD_SHOW,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] level;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/rgbls_stream_if.sv */
// Valid/ready stream channel carrying one payload per transfer.
// Payload type is a parameter; used with the types of rgbls_pkg.
`default_nettype none

interface rgbls_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/rgb_led_strip_frame_driver_top.sv */
// Top level of the RGB LED strip frame driver: configuration registers,
// front end, command queue and back end. Depends on rgbls_pkg and all rtl modules.
//
// After reset the frame store is cleared, one byte a cycle; no input transfer is
// taken meanwhile. A tick that ends a byte other than the last passes through
// ST_TICK_LD, where the next byte is fetched from the store. Start show loads
// the first byte in ST_SHOW_LD; a pixel write stores three bytes through the
// single write port in ST_WR_R, ST_WR_G and ST_WR_B. A brightness change runs
// the divider (ST_DIV), then the read-modify-write walk (ST_SCALE) over the store;
// a change from level zero skips the divider. A result waiting in the output
// register does not stop the front end, which keeps filling the command queue.
`default_nettype none

module rgb_led_strip_frame_driver_top
  import rgbls_pkg::*;
#(
  parameter int MAX_LEDS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rgbls_stream_if.sink          in_ch,
  rgbls_stream_if.source        out_ch
);

  cfg_t cfg_r;
  logic clearing;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_din;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_count        <= RST_LED_COUNT;
      cfg_r.red_offset       <= RST_RED_OFFSET;
      cfg_r.green_offset     <= RST_GREEN_OFFSET;
      cfg_r.blue_offset      <= RST_BLUE_OFFSET;
      cfg_r.zero_high_ticks  <= RST_ZERO_HIGH;
      cfg_r.one_high_ticks   <= RST_ONE_HIGH;
      cfg_r.bit_period_ticks <= RST_BIT_PERIOD;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LED_COUNT:    cfg_r.led_count        <= cfg_wdata;
        CFG_RED_OFFSET:   cfg_r.red_offset       <= cfg_wdata[1:0];
        CFG_GREEN_OFFSET: cfg_r.green_offset     <= cfg_wdata[1:0];
        CFG_BLUE_OFFSET:  cfg_r.blue_offset      <= cfg_wdata[1:0];
        CFG_ZERO_HIGH:    cfg_r.zero_high_ticks  <= cfg_wdata[7:0];
        CFG_ONE_HIGH:     cfg_r.one_high_ticks   <= cfg_wdata[7:0];
        CFG_BIT_PERIOD:   cfg_r.bit_period_ticks <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  rgbls_front #(.MAX_LEDS(MAX_LEDS)) u_front (
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_din    (q_din)
  );

  rgbls_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  rgbls_back #(.MAX_LEDS(MAX_LEDS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

  a_no_accept_while_clearing : assert property (
    @(posedge clk) disable iff (!rst_n) clearing |-> !in_ch.ready)
    else $error("input taken during frame store clear");

  a_no_push_when_full : assert property (
    @(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("command queue overflow");

  a_done_implies_sending : assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.frame_done) |-> out_ch.data.sending)
    else $error("frame_done without sending");

  a_reject_is_quiet : assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.rejected) |->
      (!out_ch.data.pin_level && !out_ch.data.frame_done))
    else $error("rejected result drives the line");

  a_pop_only_when_ready : assert property (
    @(posedge clk) disable iff (!rst_n) q_pop |-> (!q_empty && !clearing))
    else $error("command taken from empty queue");

endmodule

`default_nettype wire

/* rtl/rgbls_front.sv */
// Front end: takes input transfers and classifies them into commands.
// Depends on rgbls_pkg and rgbls_stream_if.
`default_nettype none

module rgbls_front
  import rgbls_pkg::*;
#(
  parameter int MAX_LEDS = 256
) (
  rgbls_stream_if.sink in_ch,
  input  cfg_t         cfg,
  input  logic         clearing,
  input  logic         q_full,
  output logic         q_push,
  output cmd_t         q_din
);

  localparam int LED_W = $clog2(MAX_LEDS + 1);

  logic [LED_W-1:0] active;

  assign active = (32'(cfg.led_count) > MAX_LEDS) ? LED_W'(MAX_LEDS)
                                                   : LED_W'(cfg.led_count);

  assign in_ch.ready = !q_full && !clearing;
  assign q_push      = in_ch.valid && in_ch.ready;

  always_comb begin
    q_din.pixel_index = in_ch.data.pixel_index;
    q_din.red         = in_ch.data.red;
    q_din.green       = in_ch.data.green;
    q_din.blue        = in_ch.data.blue;
    q_din.level       = in_ch.data.level;
    case (in_ch.data.action)
      ACT_WRITE: begin
        q_din.kind = (32'(in_ch.data.pixel_index) < 32'(active)) ? CMD_WRITE : CMD_REJECT;
      end
      ACT_BRIGHT: q_din.kind = CMD_BRIGHT;
      ACT_SHOW:   q_din.kind = CMD_SHOW;
      default:    q_din.kind = CMD_TICK;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rgbls_queue.sv */
// Short command queue between the front end and the back end.
// Depends on rgbls_pkg.
`default_nettype none

module rgbls_queue
  import rgbls_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  cmd_t         slots_r [QUEUE_DEPTH];
  logic [QAW:0] wr_ptr_r;
  logic [QAW:0] rd_ptr_r;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[QAW] != rd_ptr_r[QAW]) &&
                 (wr_ptr_r[QAW-1:0] == rd_ptr_r[QAW-1:0]);
  assign dout  = slots_r[rd_ptr_r[QAW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots_r[wr_ptr_r[QAW-1:0]] <= din;
    end
  end

endmodule

`default_nettype wire

/* rtl/rgbls_back.sv */
// Back end: frame store, brightness divider and rescale walk, pixel writes,
// bit serializer and the result register. Depends on rgbls_pkg, rgbls_stream_if.
`default_nettype none

module rgbls_back
  import rgbls_pkg::*;
#(
  parameter int MAX_LEDS = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cfg_t           cfg,
  input  logic           q_empty,
  input  cmd_t           q_head,
  output logic           q_pop,
  output logic           clearing,
  rgbls_stream_if.source out_ch
);

  localparam int STORE = 3 * MAX_LEDS;
  localparam int AW    = $clog2(STORE);
  localparam int PTR_W = $clog2(STORE + 1);
  localparam int LED_W = $clog2(MAX_LEDS + 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_R,
    ST_WR_G,
    ST_WR_B,
    ST_DIV,
    ST_SCALE,
    ST_SHOW_LD,
    ST_TICK_LD,
    ST_HOLD
  } state_t;

  state_t           state_r;
  logic [AW-1:0]    clr_cnt_r;
  logic [7:0]       mem [STORE];
  logic [7:0]       rdata_r;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AW-1:0]    mem_raddr;

  logic [7:0]       bright_r;
  logic [7:0]       nb_r;
  logic [7:0]       div_r;
  logic [15:0]      quo_r;
  logic [7:0]       rem_r;
  logic [3:0]       div_cnt_r;
  logic [PTR_W-1:0] walk_r;
  logic             pend_r;
  logic [AW-1:0]    pend_addr_r;

  logic [AW-1:0]    base_r;
  logic [7:0]       sr_r;
  logic [7:0]       sg_r;
  logic [7:0]       sb_r;

  logic             show_r;
  logic [PTR_W-1:0] ptr_r;
  logic [7:0]       shift_r;
  logic [2:0]       bit_cnt_r;
  logic [7:0]       tick_r;

  out_item_t        res_r;
  out_item_t        tick_res_r;
  out_item_t        out_data_r;
  logic             out_valid_r;

  logic [LED_W-1:0] active;
  logic [PTR_W-1:0] n_bytes;
  logic             out_free;
  logic             fin;
  out_item_t        fin_res;
  logic [7:0]       nb;
  logic [7:0]       high;
  logic             tick_pin;
  logic             bit_end;
  logic             last_byte;
  logic             word_end;
  logic [8:0]       div_trial;
  logic             div_ge;
  logic [8:0]       div_diff;
  logic [23:0]      scale_prod;
  logic [15:0]      prod_r;
  logic [15:0]      prod_g;
  logic [15:0]      prod_b;

  assign active  = (32'(cfg.led_count) > MAX_LEDS) ? LED_W'(MAX_LEDS)
                                                    : LED_W'(cfg.led_count);
  assign n_bytes = PTR_W'(32'(active) * 32'd3);

  assign out_free   = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign clearing   = (state_r == ST_CLEAR);

  assign nb        = q_head.level + 8'd1;
  assign high      = shift_r[7] ? cfg.one_high_ticks : cfg.zero_high_ticks;
  assign tick_pin  = (tick_r < high);
  assign bit_end   = ({1'b0, tick_r} + 9'd1) >= {1'b0, cfg.bit_period_ticks};
  assign last_byte = (ptr_r >= n_bytes);
  assign word_end  = bit_end && (bit_cnt_r == 3'd7);

  assign div_trial = {rem_r, quo_r[15]};
  assign div_ge    = (div_trial >= {1'b0, div_r});
  assign div_diff  = div_trial - {1'b0, div_r};

  assign scale_prod = {16'd0, rdata_r} * {8'd0, quo_r};
  assign prod_r     = q_head.red   * bright_r;
  assign prod_g     = q_head.green * bright_r;
  assign prod_b     = q_head.blue  * bright_r;

  always_comb begin
    q_pop     = 1'b0;
    fin       = 1'b0;
    fin_res   = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_head.kind)
            CMD_REJECT: begin
              fin              = 1'b1;
              fin_res.sending  = show_r;
              fin_res.rejected = 1'b1;
            end
            CMD_BRIGHT: begin
              if (nb == bright_r) begin
                fin             = 1'b1;
                fin_res.sending = show_r;
              end
            end
            CMD_SHOW: begin
              if (n_bytes == '0) begin
                fin             = 1'b1;
                fin_res.sending = show_r;
              end
            end
            CMD_TICK: begin
              if (!show_r) begin
                fin = 1'b1;
              end else if (!(word_end && !last_byte)) begin
                fin                = 1'b1;
                fin_res.pin_level  = tick_pin;
                fin_res.sending    = 1'b1;
                fin_res.frame_done = word_end;
              end else begin
                mem_raddr = ptr_r[AW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      ST_WR_R: begin
        mem_we    = (cfg.red_offset != OFF_NONE);
        mem_waddr = base_r + AW'(cfg.red_offset);
        mem_wdata = sr_r;
      end
      ST_WR_G: begin
        mem_we    = (cfg.green_offset != OFF_NONE);
        mem_waddr = base_r + AW'(cfg.green_offset);
        mem_wdata = sg_r;
      end
      ST_WR_B: begin
        mem_we          = (cfg.blue_offset != OFF_NONE);
        mem_waddr       = base_r + AW'(cfg.blue_offset);
        mem_wdata       = sb_r;
        fin             = 1'b1;
        fin_res.sending = show_r;
      end
      ST_SCALE: begin
        if (walk_r < n_bytes) begin
          mem_raddr = walk_r[AW-1:0];
        end
        mem_we    = pend_r;
        mem_waddr = pend_addr_r;
        mem_wdata = scale_prod[15:8];
        if (walk_r >= n_bytes && !pend_r) begin
          fin             = 1'b1;
          fin_res.sending = show_r;
        end
      end
      ST_SHOW_LD: begin
        fin             = 1'b1;
        fin_res.sending = 1'b1;
      end
      ST_TICK_LD: begin
        fin     = 1'b1;
        fin_res = tick_res_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      bright_r    <= '0;
      show_r      <= 1'b0;
      ptr_r       <= '0;
      shift_r     <= '0;
      bit_cnt_r   <= '0;
      tick_r      <= '0;
      pend_r      <= 1'b0;
      walk_r      <= '0;
      div_cnt_r   <= '0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(STORE - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            case (q_head.kind)
              CMD_WRITE: begin
                base_r  <= AW'(32'(q_head.pixel_index) * 32'd3);
                sr_r    <= (bright_r != '0) ? prod_r[15:8] : q_head.red;
                sg_r    <= (bright_r != '0) ? prod_g[15:8] : q_head.green;
                sb_r    <= (bright_r != '0) ? prod_b[15:8] : q_head.blue;
                state_r <= ST_WR_R;
              end
              CMD_BRIGHT: begin
                if (nb != bright_r) begin
                  nb_r      <= nb;
                  div_r     <= bright_r - 8'd1;
                  rem_r     <= '0;
                  div_cnt_r <= '0;
                  walk_r    <= '0;
                  pend_r    <= 1'b0;
                  if (bright_r == 8'd1) begin
                    quo_r   <= '0;
                    state_r <= ST_SCALE;
                  end else begin
                    quo_r   <= (q_head.level == 8'hFF) ? FULL_SCALE_NUM
                                                       : {nb, 8'h00} - 16'd1;
                    state_r <= ST_DIV;
                  end
                end
              end
              CMD_SHOW: begin
                if (n_bytes != '0) begin
                  state_r <= ST_SHOW_LD;
                end
              end
              CMD_TICK: begin
                if (show_r) begin
                  if (bit_end) begin
                    tick_r <= '0;
                    if (bit_cnt_r == 3'd7) begin
                      if (last_byte) begin
                        show_r    <= 1'b0;
                        bit_cnt_r <= '0;
                        shift_r   <= '0;
                      end else begin
                        tick_res_r <= '{pin_level: tick_pin, sending: 1'b1,
                                        frame_done: 1'b0, rejected: 1'b0};
                        state_r    <= ST_TICK_LD;
                      end
                    end else begin
                      shift_r   <= {shift_r[6:0], 1'b0};
                      bit_cnt_r <= bit_cnt_r + 3'd1;
                    end
                  end else begin
                    tick_r <= tick_r + 8'd1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_WR_R: state_r <= ST_WR_G;
        ST_WR_G: state_r <= ST_WR_B;
        ST_DIV: begin
          rem_r     <= div_ge ? div_diff[7:0] : div_trial[7:0];
          quo_r     <= {quo_r[14:0], div_ge};
          div_cnt_r <= div_cnt_r + 4'd1;
          if (div_cnt_r == 4'd15) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (walk_r < n_bytes) begin
            walk_r      <= walk_r + 1'b1;
            pend_r      <= 1'b1;
            pend_addr_r <= walk_r[AW-1:0];
          end else begin
            pend_r <= 1'b0;
          end
          if (fin) begin
            bright_r <= nb_r;
          end
        end
        ST_SHOW_LD: begin
          shift_r   <= rdata_r;
          ptr_r     <= PTR_W'(1);
          bit_cnt_r <= '0;
          tick_r    <= '0;
          show_r    <= 1'b1;
        end
        ST_TICK_LD: begin
          shift_r   <= rdata_r;
          ptr_r     <= ptr_r + 1'b1;
          bit_cnt_r <= '0;
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (fin) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
          out_data_r  <= fin_res;
          state_r     <= ST_IDLE;
        end else begin
          res_r   <= fin_res;
          state_r <= ST_HOLD;
        end
      end
    end
  end

endmodule

`default_nettype wire
